### rtl/packbits_rle_decoder_macros.svh
// assertion macros shared by the packbits decoder rtl
`ifndef PACKBITS_RLE_DECODER_MACROS_SVH
`define PACKBITS_RLE_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBD_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PBD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/pbd_pkg.sv
// types and constants shared by the packbits decoder modules
`default_nettype none

package pbd_pkg;

  localparam int BYTES_PER_BEAT = 4;
  localparam int BYTES_IN_WORD  = 4;
  localparam int COUNT_WIDTH    = 24;
  localparam int LIMIT_W        = 24;
  localparam int ROOM_W         = LIMIT_W + 1;
  localparam int LEN_W          = 8;
  localparam int BEAT_W         = 3;

  localparam logic [7:0]         LITERAL_MAX = 8'd127;
  localparam logic [7:0]         NOOP_HEADER = 8'h80;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65535);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [31:0]       data_word;
    logic [BEAT_W-1:0] byte_count;
    logic              last_of_run;
    logic              frame_end;
  } out_t;

  // one command per accepted item: byte to expand, how many copies, frame end
  typedef struct packed {
    logic [7:0]       value;
    logic [LEN_W-1:0] len;
    logic             last;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/pbd_front.sv
// front end: accepts compressed bytes, parses packet headers, issues commands
`default_nettype none

module pbd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pbd_pkg::in_t  in_item,
  output logic               push,
  output pbd_pkg::cmd_t      push_cmd,
  input  wire logic          q_full
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] literal_left_r, literal_left_nxt;
  logic [7:0] repeat_len_r, repeat_len_nxt;
  logic [7:0] lit_dec;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign lit_dec  = literal_left_r - 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    literal_left_nxt = literal_left_r;
    repeat_len_nxt   = repeat_len_r;
    push_cmd.value   = in_item.in_byte;
    push_cmd.last    = in_item.last_in;
    push_cmd.len     = '0;
    unique case (phase_r)
      PH_LITERAL: begin
        push_cmd.len     = pbd_pkg::LEN_W'(1);
        literal_left_nxt = lit_dec;
        if (lit_dec == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_REPEAT: begin
        push_cmd.len   = repeat_len_r;
        repeat_len_nxt = '0;
        phase_nxt      = PH_HEADER;
      end
      default: begin
        if (in_item.in_byte <= pbd_pkg::LITERAL_MAX) begin
          literal_left_nxt = in_item.in_byte + 8'd1;
          phase_nxt        = PH_LITERAL;
        end else if (in_item.in_byte != pbd_pkg::NOOP_HEADER) begin
          // 257 - header, modulo 256
          repeat_len_nxt = 8'd1 - in_item.in_byte;
          phase_nxt      = PH_REPEAT;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
    endcase
    if (in_item.last_in) begin
      phase_nxt        = PH_HEADER;
      literal_left_nxt = '0;
      repeat_len_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      literal_left_r <= '0;
      repeat_len_r   <= '0;
    end else if (push) begin
      phase_r        <= phase_nxt;
      literal_left_r <= literal_left_nxt;
      repeat_len_r   <= repeat_len_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pbd_queue.sv
// short command queue between the parser and the expander
`default_nettype none

`include "packbits_rle_decoder_macros.svh"

module pbd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pbd_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output pbd_pkg::cmd_t      head
);

  pbd_pkg::cmd_t                slot_r [pbd_pkg::QUEUE_DEPTH];
  logic [pbd_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [pbd_pkg::QCNT_W-1:0]   count_r, count_nxt;

  function automatic logic [pbd_pkg::QPTR_W-1:0] ptr_inc(
    input logic [pbd_pkg::QPTR_W-1:0] p
  );
    return (p == pbd_pkg::QPTR_W'(pbd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count_r == pbd_pkg::QCNT_W'(pbd_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

  `PBD_ASSERT(a_q_no_overflow, push, !full, "command pushed into a full queue")
  `PBD_ASSERT(a_q_no_underflow, pop, !empty, "command popped from an empty queue")

endmodule

`default_nettype wire

### rtl/pbd_back.sv
// back end: clips each command to the frame limit and emits packed result beats
`default_nettype none

`include "packbits_rle_decoder_macros.svh"

module pbd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [pbd_pkg::LIMIT_W-1:0]   output_limit,
  input  wire logic                          q_empty,
  input  wire pbd_pkg::cmd_t                 q_head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pbd_pkg::out_t                      out_item
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_CLIP = 3'b010,
    B_EMIT = 3'b100
  } bstate_t;

  bstate_t                           state_r, state_nxt;
  pbd_pkg::cmd_t                     cmd_r, cmd_nxt;
  logic [pbd_pkg::ROOM_W-1:0]        room_r, room_nxt;
  logic [pbd_pkg::LEN_W-1:0]         rem_r, rem_nxt;
  logic [pbd_pkg::COUNT_WIDTH-1:0]   emitted_r, emitted_nxt;
  logic                              frame_full_r, frame_full_nxt;
  logic                              out_valid_r, out_valid_nxt;
  pbd_pkg::out_t                     out_item_r, out_item_nxt;

  logic                              slot_free;
  logic                              full_now;
  logic [pbd_pkg::BEAT_W-1:0]        beat_len;
  logic [pbd_pkg::ROOM_W-1:0]        room_after;
  logic                              hit;
  logic                              final_beat;
  logic                              has_bytes;
  logic [31:0]                       beat_word;
  pbd_pkg::out_t                     beat_item;

  assign slot_free  = !out_valid_r || out_ready;
  assign full_now   = frame_full_r || room_r[pbd_pkg::ROOM_W-1] ||
                      (room_r[pbd_pkg::LIMIT_W-1:0] == '0);
  assign beat_len   = (rem_r < pbd_pkg::LEN_W'(pbd_pkg::BYTES_PER_BEAT)) ?
                      rem_r[pbd_pkg::BEAT_W-1:0] :
                      pbd_pkg::BEAT_W'(pbd_pkg::BYTES_PER_BEAT);
  assign room_after = room_r - pbd_pkg::ROOM_W'(beat_len);
  assign hit        = (room_after == '0);
  assign has_bytes  = (rem_r != '0);
  assign final_beat = (rem_r <= pbd_pkg::LEN_W'(pbd_pkg::BYTES_PER_BEAT));

  always_comb begin
    for (int j = 0; j < pbd_pkg::BYTES_IN_WORD; j++) begin
      beat_word[8*j +: 8] = (j < int'(beat_len)) ? cmd_r.value : 8'h00;
    end
  end

  always_comb begin
    beat_item.data_word   = beat_word;
    beat_item.byte_count  = beat_len;
    beat_item.last_of_run = final_beat;
    beat_item.frame_end   = (has_bytes && hit) || (final_beat && cmd_r.last);
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    room_nxt       = room_r;
    rem_nxt        = rem_r;
    emitted_nxt    = emitted_r;
    frame_full_nxt = frame_full_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    pop            = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cmd_nxt   = q_head;
          room_nxt  = pbd_pkg::ROOM_W'(output_limit) - pbd_pkg::ROOM_W'(emitted_r);
          state_nxt = B_CLIP;
        end
      end
      B_CLIP: begin
        if (full_now) begin
          frame_full_nxt = 1'b1;
          rem_nxt        = '0;
        end else if (room_r < pbd_pkg::ROOM_W'(cmd_r.len)) begin
          rem_nxt = room_r[pbd_pkg::LEN_W-1:0];
        end else begin
          rem_nxt = cmd_r.len;
        end
        if ((full_now || cmd_r.len == '0) && !cmd_r.last) begin
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = beat_item;
          if (has_bytes) begin
            rem_nxt     = rem_r - pbd_pkg::LEN_W'(beat_len);
            room_nxt    = room_after;
            emitted_nxt = emitted_r + pbd_pkg::COUNT_WIDTH'(beat_len);
            if (hit) begin
              frame_full_nxt = 1'b1;
            end
          end
          if (final_beat) begin
            state_nxt = B_IDLE;
            if (cmd_r.last) begin
              emitted_nxt    = '0;
              frame_full_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    room_r     <= room_nxt;
    rem_r      <= rem_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      emitted_r    <= '0;
      frame_full_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      emitted_r    <= emitted_nxt;
      frame_full_r <= frame_full_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PBD_ASSERT(a_marker_closes, out_valid && out_item.byte_count == '0,
              out_item.frame_end && out_item.last_of_run, "empty result is not a frame end")
  `PBD_ASSERT(a_run_fits_room, state_r == B_EMIT, room_r >= pbd_pkg::ROOM_W'(rem_r),
              "pending run exceeds remaining room")
  `PBD_ASSERT_NEXT(a_frame_restart,
                   state_r == B_EMIT && slot_free && final_beat && cmd_r.last,
                   emitted_r == '0 && !frame_full_r, "frame counters not cleared at frame end")

endmodule

`default_nettype wire

### rtl/packbits_rle_decoder.sv
// top level of the packbits run-length decoder
//
//   port group  dir  payload                     purpose
//   in_*        in   pbd_pkg::in_t  (9 bits)     compressed byte and frame-last flag
//   out_*       out  pbd_pkg::out_t (37 bits)    up to four decoded bytes per item
//   cfg_*       in   24-bit output limit         decoded bytes allowed per frame
//
// an item passes the expander's idle and clip states, then its beats: none for a
// header or dropped byte not ending the frame, one for a literal byte, ceil(n/4)
// for n kept repeat bytes; unstalled, the one-beat-per-cycle loop sets the rate.
// a two-entry command queue lets input keep flowing while the expander works.
// reset is synchronous, active low; the output limit resets to 65535.
// out_ready low holds the expander; in_ready drops while the queue is full.
`default_nettype none

module packbits_rle_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire pbd_pkg::in_t                 in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output pbd_pkg::out_t                     out_item,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pbd_pkg::LIMIT_W-1:0]  cfg_output_limit
);

  logic [pbd_pkg::LIMIT_W-1:0] output_limit_r;
  logic                        push;
  pbd_pkg::cmd_t               push_cmd;
  logic                        q_full;
  logic                        q_empty;
  logic                        pop;
  pbd_pkg::cmd_t               q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_limit_r <= pbd_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      output_limit_r <= cfg_output_limit;
    end
  end

  pbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  pbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  pbd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .output_limit (output_limit_r),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item)
  );

endmodule

`default_nettype wire
